FILE: sv/assert_macros.svh
// Assertion macros shared by the unfilter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, switched off while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pngu_pkg.sv
package pngu_pkg;

  // Highest legal filter type byte.
  localparam logic [7:0] HIGHEST_FILTER = 8'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd0;
  localparam logic [1:0] REG_ROW_BYTES       = 2'd1;
  localparam logic [1:0] REG_IMAGE_ROWS      = 2'd2;

  typedef enum logic [2:0] {
    FILT_NONE    = 3'd0,
    FILT_SUB     = 3'd1,
    FILT_UP      = 3'd2,
    FILT_AVERAGE = 3'd3,
    FILT_PAETH   = 3'd4
  } filter_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       last_in_row;
    logic       last_in_image;
    logic       bad_filter;
  } pixel_t;

endpackage

FILE: sv/pngu_byte_if.sv
interface pngu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

FILE: sv/pngu_pixel_if.sv
interface pngu_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       last_in_row;
  logic       last_in_image;
  logic       bad_filter;

  modport source (output valid, output pixel_byte, output last_in_row,
                  output last_in_image, output bad_filter, input ready);
  modport sink (input valid, input pixel_byte, input last_in_row,
                input last_in_image, input bad_filter, output ready);
endinterface

FILE: sv/pngu_ram.sv
// Single write port, single registered read port. A read of the address being
// written returns the old contents.
module pngu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/pngu_predict.sv
// Filter prediction and reconstruction of one channel byte.
module pngu_predict (
  input  pngu_pkg::filter_t filter,
  input  logic [7:0]        a,
  input  logic [7:0]        b,
  input  logic [7:0]        c,
  input  logic [7:0]        data_byte,
  output logic [7:0]        value
);

  logic [8:0] sum_ab;
  logic [7:0] pa;
  logic [7:0] pb;
  logic [9:0] sum_wide;
  logic [9:0] c_twice;
  logic [9:0] pc;
  logic [7:0] paeth;
  logic [7:0] pred;

  always_comb begin
    sum_ab   = {1'b0, a} + {1'b0, b};
    pa       = (b >= c) ? (b - c) : (c - b);
    pb       = (a >= c) ? (a - c) : (c - a);
    sum_wide = {1'b0, sum_ab};
    c_twice  = {1'b0, c, 1'b0};
    pc       = (sum_wide >= c_twice) ? (sum_wide - c_twice) : (c_twice - sum_wide);
    // Ties go to a, then to b, as the standard predictor requires.
    if ({2'b00, pa} <= {2'b00, pb} && {2'b00, pa} <= pc) begin
      paeth = a;
    end else if ({2'b00, pb} <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  end

  always_comb begin
    unique case (filter)
      pngu_pkg::FILT_NONE:    pred = 8'd0;
      pngu_pkg::FILT_SUB:     pred = a;
      pngu_pkg::FILT_UP:      pred = b;
      pngu_pkg::FILT_AVERAGE: pred = sum_ab[8:1];
      pngu_pkg::FILT_PAETH:   pred = paeth;
      default:                pred = 8'd0;
    endcase
    value = data_byte + pred;
  end

endmodule

FILE: sv/pngu_skid.sv
`include "assert_macros.svh"

// Two-entry output buffer: an output register and a skid register behind it.
// There is room for a new item whenever the skid register is empty, so the
// upstream side never waits on the downstream ready combinationally.
module pngu_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pngu_pkg::pixel_t push_data,
  output logic             space,
  pngu_pixel_if.source     out
);

  logic             out_valid;
  pngu_pkg::pixel_t out_data;
  logic             skid_valid;
  pngu_pkg::pixel_t skid_data;
  logic             pop;

  assign pop   = out_valid && out.ready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data <= push_data;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end
  end

  assign out.valid         = out_valid;
  assign out.pixel_byte    = out_data.pixel_byte;
  assign out.last_in_row   = out_data.last_in_row;
  assign out.last_in_image = out_data.last_in_image;
  assign out.bad_filter    = out_data.bad_filter;

  `ASSERT_IMPL(a_skid_behind_out, clk, rst, skid_valid, out_valid, "skid holds an item while output is empty")
  `ASSERT_NEXT(a_stall_fills_skid, clk, rst, push && out_valid && !pop, skid_valid, "item pushed during a stall was lost")

endmodule

FILE: sv/png_scanline_unfilter_core.sv
// Channel       Direction  Payload                                          Handshake
// bytes_in      in         data_byte                                        valid/ready
// pixels_out    out        pixel_byte, last_in_row, last_in_image, bad_filter valid/ready
// cfg           in         cfg_index, cfg_data                              cfg_write
//
// One input item can be taken in every cycle. Its result, if any, is offered from
// the next cycle unless older items wait. The row store is read ahead, at the
// column the next item will use, so the byte above is ready without a wait.
// Reset is synchronous and needs no clearing pass: the row store is only read
// at columns written on the row before. Stalls downstream are absorbed by a
// two-entry output buffer; bytes_in.ready falls only when both entries are full.
`include "assert_macros.svh"

module png_scanline_unfilter_core #(
  parameter int MAX_ROW_BYTES   = 8192,
  parameter int MAX_PIXEL_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  pngu_byte_if.sink   bytes_in,
  pngu_pixel_if.source pixels_out
);

  localparam int CW  = $clog2(MAX_ROW_BYTES);
  localparam int PIW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  // Configuration registers.
  logic [2:0]  bytes_per_pixel;
  logic [13:0] row_bytes;
  logic [15:0] image_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= 3'd1;
      row_bytes       <= 14'd1;
      image_rows      <= 16'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pngu_pkg::REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[2:0];
        pngu_pkg::REG_ROW_BYTES:       row_bytes       <= cfg_data[13:0];
        pngu_pkg::REG_IMAGE_ROWS:      image_rows      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Scan state.
  logic [CW-1:0]     column_count;
  logic [CW-1:0]     column_next;
  logic [15:0]       row_count;
  pngu_pkg::filter_t active_filter;
  logic              awaiting_filter;
  logic              on_first_row;
  logic              halted;
  logic [7:0]        left_bytes       [MAX_PIXEL_BYTES];
  logic [7:0]        upper_left_bytes [MAX_PIXEL_BYTES];

  logic accept;
  logic space;
  logic filter_step;
  logic data_step;
  logic bad_step;

  assign bytes_in.ready = space;
  assign accept      = bytes_in.valid && space;
  assign filter_step = accept && !halted && awaiting_filter;
  assign bad_step    = filter_step && (bytes_in.data_byte > pngu_pkg::HIGHEST_FILTER);
  assign data_step   = accept && !halted && !awaiting_filter;

  // Pixel width and row geometry, with out-of-range settings folded in.
  logic [3:0]     bpp_wide;
  logic [3:0]     sel_wide;
  logic [PIW-1:0] sel;
  logic [16:0]    len;
  logic [16:0]    rows;
  logic [16:0]    col_plus;
  logic [16:0]    row_plus;
  logic           end_row;
  logic           end_image;

  always_comb begin
    bpp_wide = {1'b0, bytes_per_pixel};
    if (bpp_wide == 4'd0) begin
      sel_wide = 4'd0;
    end else if (bpp_wide > 4'(MAX_PIXEL_BYTES)) begin
      sel_wide = 4'(MAX_PIXEL_BYTES - 1);
    end else begin
      sel_wide = bpp_wide - 4'd1;
    end
    sel = sel_wide[PIW-1:0];

    if (row_bytes == 14'd0) begin
      len = 17'd1;
    end else if ({3'b000, row_bytes} > 17'(MAX_ROW_BYTES)) begin
      len = 17'(MAX_ROW_BYTES);
    end else begin
      len = {3'b000, row_bytes};
    end
    rows      = (image_rows == 16'd0) ? 17'd1 : {1'b0, image_rows};
    col_plus  = 17'(column_count) + 17'd1;
    row_plus  = {1'b0, row_count} + 17'd1;
    end_row   = col_plus >= len;
    end_image = end_row && (row_plus >= rows);
  end

  // The column the next item will use; the row store is read there now.
  always_comb begin
    if (filter_step || (data_step && end_row)) begin
      column_next = '0;
    end else if (data_step) begin
      column_next = col_plus[CW-1:0];
    end else begin
      column_next = column_count;
    end
  end

  // Row store with a bypass for a write and read at the same column, which
  // happens when a row is one byte long.
  logic [7:0] ram_rdata;
  logic       bypass_hit;
  logic [7:0] bypass_data;
  logic [7:0] value;

  pngu_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_row_store (
    .clk   (clk),
    .we    (data_step),
    .waddr (column_count),
    .wdata (value),
    .raddr (column_next),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass_hit <= 1'b0;
    end else begin
      bypass_hit <= data_step && (column_count == column_next);
    end
    bypass_data <= value;
  end

  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] c;

  assign a = left_bytes[sel];
  assign c = upper_left_bytes[sel];
  assign b = on_first_row ? 8'd0 : (bypass_hit ? bypass_data : ram_rdata);

  pngu_predict u_predict (
    .filter    (active_filter),
    .a         (a),
    .b         (b),
    .c         (c),
    .data_byte (bytes_in.data_byte),
    .value     (value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= 16'd0;
      active_filter   <= pngu_pkg::FILT_NONE;
      awaiting_filter <= 1'b1;
      on_first_row    <= 1'b1;
      halted          <= 1'b0;
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_bytes[k]       <= 8'd0;
        upper_left_bytes[k] <= 8'd0;
      end
    end else begin
      column_count <= column_next;
      if (bad_step) begin
        halted <= 1'b1;
      end else if (filter_step) begin
        active_filter   <= pngu_pkg::filter_t'(bytes_in.data_byte[2:0]);
        awaiting_filter <= 1'b0;
        for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
          left_bytes[k]       <= 8'd0;
          upper_left_bytes[k] <= 8'd0;
        end
      end else if (data_step) begin
        left_bytes[0]       <= value;
        upper_left_bytes[0] <= b;
        for (int k = 1; k < MAX_PIXEL_BYTES; k++) begin
          left_bytes[k]       <= left_bytes[k-1];
          upper_left_bytes[k] <= upper_left_bytes[k-1];
        end
        if (end_row) begin
          awaiting_filter <= 1'b1;
          if (end_image) begin
            row_count    <= 16'd0;
            on_first_row <= 1'b1;
          end else begin
            row_count    <= row_plus[15:0];
            on_first_row <= 1'b0;
          end
        end
      end
    end
  end

  // Result of the item accepted in this cycle.
  pngu_pkg::pixel_t result;
  logic             push;

  always_comb begin
    push = bad_step || data_step;
    if (bad_step) begin
      result.pixel_byte    = 8'd0;
      result.last_in_row   = 1'b0;
      result.last_in_image = 1'b0;
      result.bad_filter    = 1'b1;
    end else begin
      result.pixel_byte    = value;
      result.last_in_row   = end_row;
      result.last_in_image = end_image;
      result.bad_filter    = 1'b0;
    end
  end

  pngu_skid u_out_buffer (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .space     (space),
    .out       (pixels_out)
  );

  `ASSERT_NEXT(a_halt_sticks, clk, rst, halted, halted,
    "block left the halted state without reset")
  `ASSERT_NEXT(a_row_end_waits_filter, clk, rst, data_step && end_row,
    awaiting_filter && (column_count == '0), "row end did not rearm the filter byte")
  `ASSERT_IMPL(a_image_end_is_row_end, clk, rst, push && result.last_in_image,
    result.last_in_row, "image end marked off a row end")

endmodule
